### src/imu_angle_frame_parser_macros.svh
// Assertion helpers for the angle frame parser.
`ifndef IMU_ANGLE_FRAME_PARSER_MACROS_SVH
`define IMU_ANGLE_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define IAFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define IAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### src/imuafp_pkg.sv
`default_nettype none

package imuafp_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_BYTE   = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_PACKET_TYPE = 1'b1;

    localparam logic [7:0] SyncByteReset   = 8'h55;
    localparam logic [7:0] PacketTypeReset = 8'h53;

    // Frame layout: two header bytes, eight payload bytes, one checksum byte
    localparam logic [3:0] FirstBodyIdx = 4'd2;
    localparam logic [3:0] ChecksumIdx  = 4'd10;
    localparam int unsigned BodyBytes   = 8;
    localparam int unsigned BodyIdxW    = 3;

    // Angle: floor(raw * 18000 / 2^15)
    localparam logic signed [31:0] AngleScale = 32'sd18000;

    // Temperature: floor((raw*5 + 163880) / 17) - 9640 + 3653
    localparam logic signed [19:0] TempBias   = 20'sd163880;
    localparam logic [38:0]        TempRecip  = 39'd986896;  // ceil(2^24 / 17)
    localparam int unsigned        TempShift  = 24;
    localparam logic [14:0]        TempOffset = 15'd5987;

    typedef enum logic [2:0] {
        ST_HUNT = 3'b001,
        ST_TYPE = 3'b010,
        ST_BODY = 3'b100
    } parse_state_t;

    function automatic logic signed [15:0] angle_to_centideg(input logic signed [15:0] raw);
        logic signed [31:0] prod;
        prod = 32'(raw) * AngleScale;
        return prod[30:15];
    endfunction

    function automatic logic [14:0] temp_to_centicelsius(input logic signed [15:0] raw);
        logic signed [19:0] raw_ext;
        logic signed [19:0] raw5;
        logic signed [19:0] biased;
        logic [18:0]        num;
        logic [38:0]        prod;
        logic [14:0]        quot;
        raw_ext = 20'(raw);
        raw5    = (raw_ext <<< 2) + raw_ext;
        biased  = raw5 + TempBias;
        num     = biased[18:0];
        prod    = 39'(num) * TempRecip;
        quot    = prod[TempShift+14:TempShift];
        return quot - TempOffset;
    endfunction

endpackage

`default_nettype wire

### src/imu_angle_frame_parser.sv
`default_nettype none
// Channel  | Ports                                           | Direction
// s_       | s_valid, s_ready, s_rx_byte                     | byte in
// m_       | m_valid, m_ready, m_roll/pitch/yaw_centideg,    | angle result out
//          | m_temp_centicelsius                             |
// cfg_     | cfg_valid, cfg_ready, cfg_index, cfg_data       | register write in
//
// One byte is taken per cycle while s_ready is high; the parser adds no wait states of its own.
// A good checksum byte puts the result in the output register on the edge that
// takes it; the angle and temperature multipliers sit between the frame byte
// registers and the output register, which sets the path length.
// Reset (aresetn low, synchronous) restarts the hunt, clears the output valid flag
// and restores the sync and packet type registers.
// s_ready drops only while a result waits and m_ready is low.

`include "imu_angle_frame_parser_macros.svh"

module imu_angle_frame_parser
    import imuafp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_rx_byte,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_roll_centideg,
    output logic signed [15:0]       m_pitch_centideg,
    output logic signed [15:0]       m_yaw_centideg,
    output logic signed [14:0]       m_temp_centicelsius,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [7:0]          cfg_data
);

    // Configuration registers
    logic [7:0] sync_byte_reg;
    logic [7:0] packet_type_reg;

    // Parser state
    parse_state_t state_reg, state_next;
    logic [3:0]   count_reg, count_next;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   body_reg [BodyBytes];
    logic         body_we;
    logic [BodyIdxW-1:0] body_idx;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [14:0] temp_reg;

    logic in_fire;
    logic load_result;
    logic last_byte;

    logic signed [15:0] raw_x, raw_y, raw_z, raw_t;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg   <= SyncByteReset;
            packet_type_reg <= PacketTypeReset;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:   sync_byte_reg   <= cfg_data;
                CFG_PACKET_TYPE: packet_type_reg <= cfg_data;
            endcase
        end
    end

    // Stall input only while a finished result is still waiting downstream.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    assign last_byte = (state_reg == ST_BODY) && (count_reg == ChecksumIdx);
    assign body_idx  = BodyIdxW'(count_reg - FirstBodyIdx);

    // Hunt for sync, then type, then collect the body with a running sum.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        body_we     = 1'b0;
        load_result = 1'b0;
        if (in_fire) begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (s_rx_byte == sync_byte_reg) begin
                        state_next = ST_TYPE;
                        sum_next   = s_rx_byte;
                    end
                end
                ST_TYPE: begin
                    // A mismatching byte restarts the hunt; it is never taken as sync.
                    if (s_rx_byte == packet_type_reg) begin
                        state_next = ST_BODY;
                        sum_next   = sum_reg + s_rx_byte;
                        count_next = FirstBodyIdx;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
                ST_BODY: begin
                    if (count_reg == ChecksumIdx) begin
                        // Drop the frame silently on a checksum mismatch.
                        state_next  = ST_HUNT;
                        count_next  = 4'd0;
                        load_result = (sum_reg == s_rx_byte);
                    end else begin
                        body_we    = 1'b1;
                        sum_next   = sum_reg + s_rx_byte;
                        count_next = count_reg + 4'd1;
                    end
                end
                default: begin
                    state_next = ST_HUNT;
                    count_next = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            count_reg <= 4'd0;
            sum_reg   <= 8'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Hold payload bytes 2..9; no reset needed.
    always_ff @(posedge aclk) begin
        if (body_we) begin
            body_reg[body_idx] <= s_rx_byte;
        end
    end

    // Little-endian words
    assign raw_x = {body_reg[1], body_reg[0]};
    assign raw_y = {body_reg[3], body_reg[2]};
    assign raw_z = {body_reg[5], body_reg[4]};
    assign raw_t = {body_reg[7], body_reg[6]};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Convert and load the result on the edge that takes a good checksum byte.
    always_ff @(posedge aclk) begin
        if (load_result) begin
            roll_reg  <= angle_to_centideg(raw_x);
            pitch_reg <= angle_to_centideg(raw_y);
            yaw_reg   <= angle_to_centideg(raw_z);
            temp_reg  <= temp_to_centicelsius(raw_t);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_roll_centideg     = roll_reg;
    assign m_pitch_centideg    = pitch_reg;
    assign m_yaw_centideg      = yaw_reg;
    assign m_temp_centicelsius = temp_reg;

    // Body byte counter stays inside the payload and checksum span.
    `IAFP_ASSERT_NOW(a_body_count_range, aclk, aresetn,
        state_reg == ST_BODY, count_reg >= FirstBodyIdx && count_reg <= ChecksumIdx)
    // A taken checksum byte always returns the parser to the hunt.
    `IAFP_ASSERT_NEXT(a_last_byte_rehunt, aclk, aresetn,
        in_fire && last_byte, state_reg == ST_HUNT && count_reg == 4'd0)
    // A good frame always shows up as a result on the next cycle.
    `IAFP_ASSERT_NEXT(a_result_loaded, aclk, aresetn, load_result, m_valid_reg)
    // Results appear only from a good checksum byte.
    `IAFP_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn,
        !load_result && !(m_valid_reg && !m_ready), !m_valid_reg)

endmodule

`default_nettype wire
